// File: hw/rtl/tsm_pkg.sv
// Shared widths, types and lane tables for the triangle stiffness matrix core.
// No dependencies.
`default_nettype none
package tsm_pkg;
	localparam int COORD_BITS = 24;
	localparam int ENTRY_BITS = 32;
	localparam int ENTRY_FRAC = 16;
	localparam int LANES      = 6;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int DOT_W  = PROD_W + 1;
	localparam int MAG_W  = DOT_W;
	localparam int DEN_W  = MAG_W + 1;
	localparam int REM_W  = DEN_W + 1;
	localparam int Q_W    = ENTRY_BITS + 1;
	localparam int QR_W   = Q_W + 1;
	localparam int NUM_W  = MAG_W + ENTRY_FRAC;
	localparam int CMP_W  = NUM_W + DEN_W;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [DOT_W-1:0]      dot_t;
	typedef logic [MAG_W-1:0]             mag_t;
	typedef logic [DEN_W-1:0]             den_t;
	typedef logic [REM_W-1:0]             rem_t;
	typedef logic [Q_W-1:0]               q_t;
	typedef logic [QR_W-1:0]              qr_t;
	typedef logic [NUM_W-1:0]             num_t;
	typedef logic [CMP_W-1:0]             cmp_t;
	typedef logic signed [ENTRY_BITS-1:0] entry_t;

	localparam qr_t NEG_LIM = qr_t'(1) << (ENTRY_BITS - 1);
	localparam qr_t POS_LIM = NEG_LIM - qr_t'(1);

	typedef struct packed {
		logic [LANES-1:0][REM_W-1:0] rem;
		logic [LANES-1:0][Q_W-1:0]   tail;
		den_t                        den;
		logic [LANES-1:0]            neg;
		logic [LANES-1:0]            sat;
		logic                        degen;
	} div_t;

	// edge pair index: 0 = 23, 1 = 31, 2 = 12
	function automatic logic [1:0] lane_row(input logic [2:0] k);
		logic [1:0] r;
		case (k)
			3'd0, 3'd1, 3'd2: r = 2'd0;
			3'd3, 3'd4:       r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] lane_col(input logic [2:0] k);
		logic [1:0] c;
		case (k)
			3'd0:       c = 2'd0;
			3'd1, 3'd3: c = 2'd1;
			default:    c = 2'd2;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/tsm_if.sv
// Valid/ready channel interfaces for triangle corners in and matrix entries out.
// Depends on tsm_pkg.
`default_nettype none
interface tsm_in_if;
	logic            valid;
	logic            ready;
	tsm_pkg::coord_t first_x;
	tsm_pkg::coord_t first_y;
	tsm_pkg::coord_t second_x;
	tsm_pkg::coord_t second_y;
	tsm_pkg::coord_t third_x;
	tsm_pkg::coord_t third_y;
	modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
		input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
		output ready);
endinterface

interface tsm_out_if;
	logic            valid;
	logic            ready;
	tsm_pkg::entry_t entry_00;
	tsm_pkg::entry_t entry_01;
	tsm_pkg::entry_t entry_02;
	tsm_pkg::entry_t entry_11;
	tsm_pkg::entry_t entry_12;
	tsm_pkg::entry_t entry_22;
	logic            degenerate;
	modport source (output valid, entry_00, entry_01, entry_02, entry_11, entry_12, entry_22,
		degenerate, input ready);
	modport sink (input valid, entry_00, entry_01, entry_02, entry_11, entry_12, entry_22,
		degenerate, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tsm_front.sv
// Front pipeline: edge differences, products, dot sums and area, magnitudes,
// divider setup. Five stages. Depends on tsm_pkg and tsm_if.
`default_nettype none
module tsm_front (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tsm_in_if.sink      in_ch,
	output logic        out_valid,
	input  wire logic   out_ready,
	output tsm_pkg::div_t out_data
);
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	tsm_pkg::diff_t dx_s1 [3];
	tsm_pkg::diff_t dy_s1 [3];
	tsm_pkg::prod_t py_s2 [tsm_pkg::LANES];
	tsm_pkg::prod_t px_s2 [tsm_pkg::LANES];
	tsm_pkg::prod_t pa_s2, pb_s2;
	tsm_pkg::dot_t  dot_s3 [tsm_pkg::LANES];
	tsm_pkg::dot_t  area_s3;
	tsm_pkg::mag_t  mag_s4 [tsm_pkg::LANES];
	logic [tsm_pkg::LANES-1:0] neg_s4;
	tsm_pkg::den_t  den_s4;
	logic           degen_s4;
	tsm_pkg::div_t  div_s5;
	tsm_pkg::div_t  div_d;
	tsm_pkg::num_t  num_d [tsm_pkg::LANES];
	tsm_pkg::num_t  rinit_d [tsm_pkg::LANES];
	tsm_pkg::dot_t  aabs_d;

	assign rdy5 = !v_s5 || out_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ch.ready = rdy1;
	assign out_valid = v_s5;
	assign out_data = div_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_ch.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_ch.valid) begin
			dx_s1[0] <= tsm_pkg::diff_t'(in_ch.second_x) - tsm_pkg::diff_t'(in_ch.third_x);
			dx_s1[1] <= tsm_pkg::diff_t'(in_ch.third_x) - tsm_pkg::diff_t'(in_ch.first_x);
			dx_s1[2] <= tsm_pkg::diff_t'(in_ch.first_x) - tsm_pkg::diff_t'(in_ch.second_x);
			dy_s1[0] <= tsm_pkg::diff_t'(in_ch.second_y) - tsm_pkg::diff_t'(in_ch.third_y);
			dy_s1[1] <= tsm_pkg::diff_t'(in_ch.third_y) - tsm_pkg::diff_t'(in_ch.first_y);
			dy_s1[2] <= tsm_pkg::diff_t'(in_ch.first_y) - tsm_pkg::diff_t'(in_ch.second_y);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			for (int k = 0; k < tsm_pkg::LANES; k++) begin
				py_s2[k] <= tsm_pkg::prod_t'(dy_s1[tsm_pkg::lane_row(3'(k))])
					* tsm_pkg::prod_t'(dy_s1[tsm_pkg::lane_col(3'(k))]);
				px_s2[k] <= tsm_pkg::prod_t'(dx_s1[tsm_pkg::lane_row(3'(k))])
					* tsm_pkg::prod_t'(dx_s1[tsm_pkg::lane_col(3'(k))]);
			end
			pa_s2 <= tsm_pkg::prod_t'(dx_s1[1]) * tsm_pkg::prod_t'(dy_s1[2]);
			pb_s2 <= tsm_pkg::prod_t'(dx_s1[2]) * tsm_pkg::prod_t'(dy_s1[1]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			for (int k = 0; k < tsm_pkg::LANES; k++) begin
				dot_s3[k] <= tsm_pkg::dot_t'(py_s2[k]) + tsm_pkg::dot_t'(px_s2[k]);
			end
			area_s3 <= tsm_pkg::dot_t'(pa_s2) - tsm_pkg::dot_t'(pb_s2);
		end
	end

	assign aabs_d = area_s3[tsm_pkg::DOT_W-1] ? -area_s3 : area_s3;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			for (int k = 0; k < tsm_pkg::LANES; k++) begin
				mag_s4[k] <= tsm_pkg::mag_t'(dot_s3[k][tsm_pkg::DOT_W-1] ? -dot_s3[k] : dot_s3[k]);
				neg_s4[k] <= dot_s3[k][tsm_pkg::DOT_W-1] ^ area_s3[tsm_pkg::DOT_W-1];
			end
			den_s4   <= {tsm_pkg::mag_t'(aabs_d), 1'b0};
			degen_s4 <= (area_s3 == '0);
		end
	end

	always_comb begin
		div_d = '0;
		for (int k = 0; k < tsm_pkg::LANES; k++) begin
			num_d[k]   = tsm_pkg::num_t'(mag_s4[k]) << tsm_pkg::ENTRY_FRAC;
			rinit_d[k] = num_d[k] >> tsm_pkg::Q_W;
			div_d.sat[k]  = tsm_pkg::cmp_t'(rinit_d[k]) >= tsm_pkg::cmp_t'(den_s4);
			div_d.rem[k]  = tsm_pkg::rem_t'(rinit_d[k]);
			div_d.tail[k] = num_d[k][tsm_pkg::Q_W-1:0];
		end
		div_d.den   = den_s4;
		div_d.neg   = neg_s4;
		div_d.degen = degen_s4;
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			div_s5 <= div_d;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/tsm_div_stage.sv
// One restoring division step for all six lanes, quotient bit shifted into tail.
// Depends on tsm_pkg.
`default_nettype none
module tsm_div_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tsm_pkg::div_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tsm_pkg::div_t      out_data
);
	logic          v_q;
	tsm_pkg::div_t d_q;
	tsm_pkg::div_t nxt;
	tsm_pkg::rem_t r2 [tsm_pkg::LANES];
	logic [tsm_pkg::LANES-1:0] ge;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data  = d_q;

	always_comb begin
		nxt = in_data;
		for (int k = 0; k < tsm_pkg::LANES; k++) begin
			r2[k] = {in_data.rem[k][tsm_pkg::REM_W-2:0], in_data.tail[k][tsm_pkg::Q_W-1]};
			ge[k] = r2[k] >= tsm_pkg::rem_t'(in_data.den);
			nxt.rem[k]  = ge[k] ? r2[k] - tsm_pkg::rem_t'(in_data.den) : r2[k];
			nxt.tail[k] = {in_data.tail[k][tsm_pkg::Q_W-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/tsm_back.sv
// Back pipeline: round to nearest, saturate, apply sign, output register.
// Depends on tsm_pkg and tsm_if.
`default_nettype none
module tsm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tsm_pkg::div_t in_data,
	tsm_out_if.source          out_ch
);
	logic v_s1, v_s2;
	logic rdy1, rdy2;
	tsm_pkg::qr_t qr_s1 [tsm_pkg::LANES];
	logic [tsm_pkg::LANES-1:0] sat_s1, neg_s1;
	logic degen_s1;
	tsm_pkg::entry_t res_s2 [tsm_pkg::LANES];
	logic degen_s2;
	tsm_pkg::qr_t m_d [tsm_pkg::LANES];
	tsm_pkg::entry_t res_d [tsm_pkg::LANES];
	logic [tsm_pkg::LANES-1:0] rnd_d;

	assign rdy2 = !v_s2 || out_ch.ready;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < tsm_pkg::LANES; k++) begin
			rnd_d[k] = {in_data.rem[k][tsm_pkg::DEN_W-1:0], 1'b0}
				>= tsm_pkg::rem_t'(in_data.den);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int k = 0; k < tsm_pkg::LANES; k++) begin
				qr_s1[k] <= tsm_pkg::qr_t'(in_data.tail[k]) + tsm_pkg::qr_t'(rnd_d[k]);
			end
			sat_s1   <= in_data.sat;
			neg_s1   <= in_data.neg;
			degen_s1 <= in_data.degen;
		end
	end

	always_comb begin
		for (int k = 0; k < tsm_pkg::LANES; k++) begin
			if (neg_s1[k]) begin
				m_d[k] = (sat_s1[k] || qr_s1[k] > tsm_pkg::NEG_LIM) ? tsm_pkg::NEG_LIM : qr_s1[k];
				m_d[k] = ~m_d[k] + tsm_pkg::qr_t'(1);
			end else begin
				m_d[k] = (sat_s1[k] || qr_s1[k] > tsm_pkg::POS_LIM) ? tsm_pkg::POS_LIM : qr_s1[k];
			end
			res_d[k] = degen_s1 ? '0 : tsm_pkg::entry_t'(m_d[k][tsm_pkg::ENTRY_BITS-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			for (int k = 0; k < tsm_pkg::LANES; k++) begin
				res_s2[k] <= res_d[k];
			end
			degen_s2 <= degen_s1;
		end
	end

	assign out_ch.valid      = v_s2;
	assign out_ch.entry_00   = res_s2[0];
	assign out_ch.entry_01   = res_s2[1];
	assign out_ch.entry_02   = res_s2[2];
	assign out_ch.entry_11   = res_s2[3];
	assign out_ch.entry_12   = res_s2[4];
	assign out_ch.entry_22   = res_s2[5];
	assign out_ch.degenerate = degen_s2;
endmodule
`default_nettype wire

// File: hw/rtl/triangle_stiffness_matrix_core.sv
// Linear triangle stiffness matrix core, top level.
// Pipeline: 5 front stages, 33 one-bit divider stages, 2 back stages.
// Throughput: one triangle per cycle unless out_ch.ready stalls; every stage holds one item, bubbles collapse.
// Reset: arst_n asynchronously clears all stage valid bits; data registers are not reset.
// Depends on tsm_pkg, tsm_if, tsm_front, tsm_div_stage, tsm_back.
`default_nettype none
module triangle_stiffness_matrix_core (
	input  wire logic clk,
	input  wire logic arst_n,
	tsm_in_if.sink    in_ch,
	tsm_out_if.source out_ch
);
	logic          chain_v   [tsm_pkg::Q_W+1];
	logic          chain_rdy [tsm_pkg::Q_W+1];
	tsm_pkg::div_t chain_d   [tsm_pkg::Q_W+1];

	tsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_valid (chain_v[0]),
		.out_ready (chain_rdy[0]),
		.out_data  (chain_d[0])
	);

	for (genvar i = 0; i < tsm_pkg::Q_W; i++) begin : g_div
		tsm_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[i]),
			.in_ready  (chain_rdy[i]),
			.in_data   (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_ready (chain_rdy[i+1]),
			.out_data  (chain_d[i+1])
		);
	end

	tsm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_v[tsm_pkg::Q_W]),
		.in_ready (chain_rdy[tsm_pkg::Q_W]),
		.in_data  (chain_d[tsm_pkg::Q_W]),
		.out_ch   (out_ch)
	);
endmodule
`default_nettype wire
